@@ src/qbu_pkg.sv @@
// Package for the quality block unpacker: widths, the front-end phase type,
// the job record that crosses the queue, and queue status. No dependencies.
`timescale 1ns / 1ps

package qbu_pkg;

  localparam int BYTE_W     = 8;
  localparam int WIDTH_W    = 3;
  localparam int MIN_W      = 6;
  localparam int BUF_W      = 15;
  localparam int HELD_W     = 4;
  localparam int CNT_W      = 4;
  localparam int MAX_RES    = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Front-end phase, one-hot.
  typedef enum logic [3:0] {
    PH_COUNT  = 4'b0001,
    PH_HEAD1  = 4'b0010,
    PH_HEAD2  = 4'b0100,
    PH_VALUES = 4'b1000
  } phase_t;

  // One job: either a run of packed values (packed_vals set) or a single
  // result carrying the minimum and a repeat count (zero width, end of record).
  typedef struct packed {
    logic               packed_vals;
    logic [BUF_W-1:0]   buf_bits;
    logic [WIDTH_W-1:0] width;
    logic [MIN_W-1:0]   minimum;
    logic [CNT_W-1:0]   count;
    logic [BYTE_W-1:0]  rep;
    logic               rec_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ src/qbu_if.sv @@
// Channel interfaces of the quality block unpacker: byte input and result output.
// Depends on qbu_pkg for the field widths.
`timescale 1ns / 1ps

interface qbu_in_if;
  logic                       valid;
  logic                       ready;
  logic [qbu_pkg::BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface qbu_out_if;
  logic                       valid;
  logic                       ready;
  logic [qbu_pkg::BYTE_W-1:0] qual;
  logic [qbu_pkg::BYTE_W-1:0] repeat_res;
  logic                       record_end;
  logic                       last;

  modport source (output valid, output qual, output repeat_res, output record_end,
                  output last, input ready);
  modport sink   (input valid, input qual, input repeat_res, input record_end,
                  input last, output ready);
endinterface

@@ src/qbu_front.sv @@
// Front end of the quality block unpacker: parses count and header bytes,
// gathers value bits and pushes one job per byte that yields results.
// Depends on qbu_pkg and qbu_if.
`timescale 1ns / 1ps

module qbu_front (
  input  logic                clk,
  input  logic                rst_n,
  qbu_in_if.sink              in_ch,
  input  qbu_pkg::fifo_stat_t fifo_stat,
  output logic                push,
  output qbu_pkg::job_t       push_job
);

  qbu_pkg::phase_t                 phase_r, phase_nxt;
  logic [qbu_pkg::BYTE_W-1:0]      values_left_r, values_left_nxt;
  logic [qbu_pkg::WIDTH_W-1:0]     width_r, width_nxt;
  logic [qbu_pkg::MIN_W-1:0]       min_r, min_nxt;
  logic [qbu_pkg::BUF_W-1:0]       buf_r, buf_nxt;
  logic [qbu_pkg::HELD_W-1:0]      held_r, held_nxt;

  logic                            accept;
  logic [qbu_pkg::BYTE_W-1:0]      b;
  logic [qbu_pkg::BUF_W-1:0]       buf_in;
  logic [qbu_pkg::HELD_W-1:0]      held_in;
  logic [qbu_pkg::MIN_W-1:0]       min_full;
  logic [qbu_pkg::CNT_W-1:0]       n;
  logic [6:0]                      shift;
  logic [qbu_pkg::BYTE_W-1:0]      left_after;

  assign in_ch.ready = !fifo_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_in;
  assign min_full    = min_r | {b[0], 5'b0};

  // Bits available to the value drain for this byte.
  always_comb begin
    if (phase_r == qbu_pkg::PH_HEAD2) begin
      buf_in  = {8'b0, b[7:1]};
      held_in = 4'd7;
    end else begin
      buf_in  = buf_r | qbu_pkg::BUF_W'({7'b0, b} << held_r[2:0]);
      held_in = held_r + 4'd8;
    end
  end

  // Number of whole values that fit, capped by the block and by one byte's worth.
  always_comb begin
    n = '0;
    for (int k = 1; k <= qbu_pkg::MAX_RES; k++) begin
      if ((8'(k) <= values_left_r) &&
          ((7'(k) * {4'b0, width_r}) <= {3'b0, held_in})) begin
        n = qbu_pkg::CNT_W'(k);
      end
    end
    shift      = {3'b0, n} * {4'b0, width_r};
    left_after = values_left_r - {4'b0, n};
  end

  always_comb begin
    phase_nxt       = phase_r;
    values_left_nxt = values_left_r;
    width_nxt       = width_r;
    min_nxt         = min_r;
    buf_nxt         = buf_r;
    held_nxt        = held_r;
    push            = 1'b0;
    push_job        = '0;
    if (accept) begin
      case (phase_r)
        qbu_pkg::PH_COUNT: begin
          if (b == 8'd0) begin
            push             = 1'b1;
            push_job.count   = 4'd1;
            push_job.rec_end = 1'b1;
          end else begin
            values_left_nxt = b;
            phase_nxt       = qbu_pkg::PH_HEAD1;
          end
        end
        qbu_pkg::PH_HEAD1: begin
          width_nxt = b[2:0];
          min_nxt   = {1'b0, b[7:3]};
          phase_nxt = qbu_pkg::PH_HEAD2;
        end
        qbu_pkg::PH_HEAD2, qbu_pkg::PH_VALUES: begin
          if (phase_r == qbu_pkg::PH_HEAD2) begin
            min_nxt = min_full;
          end
          if (phase_r == qbu_pkg::PH_HEAD2 && width_r == 3'd0) begin
            push             = 1'b1;
            push_job.minimum = min_full;
            push_job.rep     = values_left_r;
            push_job.count   = 4'd1;
            values_left_nxt  = '0;
            buf_nxt          = '0;
            held_nxt         = '0;
            phase_nxt        = qbu_pkg::PH_COUNT;
          end else begin
            push                 = (n != '0);
            push_job.packed_vals = 1'b1;
            push_job.buf_bits    = buf_in;
            push_job.width       = width_r;
            push_job.minimum     = (phase_r == qbu_pkg::PH_HEAD2) ? min_full : min_r;
            push_job.count       = n;
            push_job.rep         = 8'd1;
            values_left_nxt      = left_after;
            if (left_after == 8'd0) begin
              buf_nxt   = '0;
              held_nxt  = '0;
              phase_nxt = qbu_pkg::PH_COUNT;
            end else begin
              buf_nxt   = buf_in >> shift;
              held_nxt  = held_in - shift[3:0];
              phase_nxt = qbu_pkg::PH_VALUES;
            end
          end
        end
        default: begin
          phase_nxt = qbu_pkg::PH_COUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= qbu_pkg::PH_COUNT;
      values_left_r <= '0;
      width_r       <= '0;
      min_r         <= '0;
      buf_r         <= '0;
      held_r        <= '0;
    end else begin
      phase_r       <= phase_nxt;
      values_left_r <= values_left_nxt;
      width_r       <= width_nxt;
      min_r         <= min_nxt;
      buf_r         <= buf_nxt;
      held_r        <= held_nxt;
    end
  end

endmodule

@@ src/qbu_fifo.sv @@
// Short job queue between the front and back ends of the quality block unpacker.
// Depends on qbu_pkg.
`timescale 1ns / 1ps

module qbu_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qbu_pkg::job_t       push_job,
  input  logic                pop,
  output qbu_pkg::job_t       head_job,
  output qbu_pkg::fifo_stat_t stat
);

  qbu_pkg::job_t              mem_r [qbu_pkg::FIFO_DEPTH];
  logic [qbu_pkg::PTR_W:0]    wr_ptr_r, wr_ptr_nxt;
  logic [qbu_pkg::PTR_W:0]    rd_ptr_r, rd_ptr_nxt;

  assign stat.empty = (wr_ptr_r == rd_ptr_r);
  assign stat.full  = (wr_ptr_r[qbu_pkg::PTR_W] != rd_ptr_r[qbu_pkg::PTR_W]) &&
                      (wr_ptr_r[qbu_pkg::PTR_W-1:0] == rd_ptr_r[qbu_pkg::PTR_W-1:0]);
  assign head_job   = mem_r[rd_ptr_r[qbu_pkg::PTR_W-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + {{qbu_pkg::PTR_W{1'b0}}, (push && !stat.full)};
  assign rd_ptr_nxt = rd_ptr_r + {{qbu_pkg::PTR_W{1'b0}}, (pop && !stat.empty)};

  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      mem_r[wr_ptr_r[qbu_pkg::PTR_W-1:0]] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

endmodule

@@ src/qbu_back.sv @@
// Back end of the quality block unpacker: expands queued jobs into results,
// one per cycle while the consumer is ready, through a registered output stage.
// Depends on qbu_pkg and qbu_if.
`timescale 1ns / 1ps

module qbu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  qbu_pkg::job_t       head_job,
  input  qbu_pkg::fifo_stat_t fifo_stat,
  output logic                pop,
  qbu_out_if.source           out_ch
);

  qbu_pkg::job_t               cur_r, cur_nxt;
  logic                        cur_valid_r, cur_valid_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [qbu_pkg::BYTE_W-1:0]  qual_r, qual_nxt;
  logic [qbu_pkg::BYTE_W-1:0]  rep_r, rep_nxt;
  logic                        end_r, end_nxt;
  logic                        last_r, last_nxt;

  logic                        emit;
  logic                        finishing;
  logic [qbu_pkg::BYTE_W-1:0]  mask;

  assign emit      = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign finishing = emit && (cur_r.count == 4'd1);
  assign pop       = !fifo_stat.empty && (!cur_valid_r || finishing);
  assign mask      = 8'((9'd1 << cur_r.width) - 9'd1);

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (pop) begin
      cur_nxt       = head_job;
      cur_valid_nxt = 1'b1;
    end else if (emit) begin
      cur_nxt.count    = cur_r.count - 4'd1;
      cur_nxt.buf_bits = cur_r.buf_bits >> cur_r.width;
      if (finishing) begin
        cur_valid_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    qual_nxt      = qual_r;
    rep_nxt       = rep_r;
    end_nxt       = end_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      qual_nxt      = {2'b0, cur_r.minimum};
      if (cur_r.packed_vals) begin
        qual_nxt = {2'b0, cur_r.minimum} + (cur_r.buf_bits[7:0] & mask);
      end
      rep_nxt  = cur_r.rep;
      end_nxt  = cur_r.rec_end;
      last_nxt = (cur_r.count == 4'd1);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    qual_r <= qual_nxt;
    rep_r  <= rep_nxt;
    end_r  <= end_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.qual       = qual_r;
  assign out_ch.repeat_res = rep_r;
  assign out_ch.record_end = end_r;
  assign out_ch.last       = last_r;

endmodule

@@ src/quality_block_unpacker.sv @@
// Top level of the quality block unpacker: front end, job queue and back end.
// Depends on qbu_pkg, qbu_if, qbu_front, qbu_fifo and qbu_back.
`timescale 1ns / 1ps

// The unpacker takes a packed quality-score stream one byte per beat and
// returns decoded results on its output channel. Each block is a count byte,
// two header bytes holding a 3-bit value width and a 6-bit minimum, and then
// the values packed LSB-first; each result is the minimum plus one value with
// a repeat of 1. A zero-width block yields a single result carrying the
// minimum and the count as repeat, and a zero count byte yields an end result
// (record_end set, qual and repeat zero). The last flag marks the final result
// caused by one input byte. One byte can be accepted every cycle as long as
// the four-entry job queue has room. The result side delivers one result per
// cycle while the consumer is ready, so the sustained byte rate is set by how
// many results the stream carries per byte (zero to eight). The first result of
// a byte passes through the job queue, the current-job register and the output
// register. The output is registered, so the input side keeps taking bytes
// while a result waits for the consumer.
module quality_block_unpacker (
  input  logic       clk,
  input  logic       rst_n,
  qbu_in_if.sink     in_ch,
  qbu_out_if.source  out_ch
);

  qbu_pkg::fifo_stat_t fifo_stat;
  qbu_pkg::job_t       push_job;
  qbu_pkg::job_t       head_job;
  logic                push;
  logic                pop;

  // Parses headers and bit-gathers; one job per byte that yields results.
  qbu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // Decouples the byte side from result back-pressure.
  qbu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (fifo_stat)
  );

  // Expands each job into results, one per cycle while the output is taken.
  qbu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // An end result is always alone for its byte and carries zeros.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.record_end |->
      out_ch.last && out_ch.repeat_res == 8'd0 && out_ch.qual == 8'd0)
    else $error("end result malformed");

  // Results with a repeat other than one come from single-result jobs.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.repeat_res != 8'd1 |-> out_ch.last)
    else $error("multi-repeat result not flagged last");

  // The queue can never look full and empty at once.
  a_fifo_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue status inconsistent");

  // A push is never attempted into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full)
    else $error("job pushed into full queue");
`endif

endmodule
